/* hdl/tile_map_store_with_tallies_macros.svh */
// ----------------------------------------------------------------------------
// Tile map store assertion macros
// Shared concurrent-assertion shorthands for the tile map store.
// ----------------------------------------------------------------------------
`ifndef TILE_MAP_STORE_WITH_TALLIES_MACROS_SVH
`define TILE_MAP_STORE_WITH_TALLIES_MACROS_SVH

// same-cycle implication, ignored while reset is high
`define TMST_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tile map store: same-cycle check failed");

// next-cycle implication, ignored while reset is high
`define TMST_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tile map store: next-cycle check failed");

`endif

/* hdl/tmst_pkg.sv */
// ----------------------------------------------------------------------------
// Tile map store package
// Map dimensions, field widths, register indexes and shared types.
// ----------------------------------------------------------------------------
package tmst_pkg;

   localparam int MAX_COLUMNS = 256;
   localparam int MAX_ROWS    = 256;
   localparam int STORE_DEPTH = MAX_COLUMNS * MAX_ROWS;
   localparam int ADDR_BITS   = $clog2(STORE_DEPTH);
   localparam int COL_BITS    = $clog2(MAX_COLUMNS);
   localparam int ROW_BITS    = $clog2(MAX_ROWS);
   localparam int EC_BITS     = $clog2(MAX_COLUMNS + 1);
   localparam int ER_BITS     = $clog2(MAX_ROWS + 1);
   localparam int PROD_BITS   = EC_BITS + ROW_BITS;

   localparam int DIM_BITS    = 9;
   localparam int CODE_BITS   = 8;
   localparam int COORD_BITS  = 16;
   localparam int TILE_BITS   = 8;
   localparam int TALLY_BITS  = 17;
   localparam int CSR_BITS    = 9;
   localparam int CSR_IDX_BITS = 2;

   localparam int REQ_TDATA_BITS = 40;
   localparam int RSP_TDATA_BITS = 48;
   localparam int RSP_PAD_BITS   = RSP_TDATA_BITS - TILE_BITS - 2 * TALLY_BITS;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   localparam logic [TALLY_BITS-1:0] TALLY_MAX = '1;

   localparam logic [DIM_BITS-1:0]  RST_MAP_COLUMNS   = 9'd256;
   localparam logic [DIM_BITS-1:0]  RST_MAP_ROWS      = 9'd256;
   localparam logic [CODE_BITS-1:0] RST_WALKABLE_CODE = 8'd255;
   localparam logic [CODE_BITS-1:0] RST_RESOURCE_CODE = 8'd128;

   localparam logic CMD_READ  = 1'b0;
   localparam logic CMD_WRITE = 1'b1;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_MAP_COLUMNS   = 2'd0,
      CSR_MAP_ROWS      = 2'd1,
      CSR_WALKABLE_CODE = 2'd2,
      CSR_RESOURCE_CODE = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [DIM_BITS-1:0]  map_columns;
      logic [DIM_BITS-1:0]  map_rows;
      logic [CODE_BITS-1:0] walkable_code;
      logic [CODE_BITS-1:0] resource_code;
   } cfg_type;

   typedef struct packed {
      logic                 cmd;
      logic                 inb;
      logic [ADDR_BITS-1:0] addr;
      logic [TILE_BITS-1:0] value;
   } qentry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

   typedef struct packed {
      logic clearing;
      logic finish;
   } bk_status_type;

   function automatic logic [EC_BITS-1:0] eff_columns(logic [DIM_BITS-1:0] v);
      logic [EC_BITS-1:0] r;
      if (int'(v) > MAX_COLUMNS) r = EC_BITS'(MAX_COLUMNS);
      else r = EC_BITS'(v);
      return r;
   endfunction

   function automatic logic [ER_BITS-1:0] eff_rows(logic [DIM_BITS-1:0] v);
      logic [ER_BITS-1:0] r;
      if (int'(v) > MAX_ROWS) r = ER_BITS'(MAX_ROWS);
      else r = ER_BITS'(v);
      return r;
   endfunction

endpackage

/* hdl/tmst_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module tmst_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/tmst_front.sv */
// ----------------------------------------------------------------------------
// Tile map store front end
// Takes request items, bounds-checks them and forms the store address.
// ----------------------------------------------------------------------------
module tmst_front import tmst_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  cfg_type                   cfg,
   input  logic                      clearing,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [REQ_TDATA_BITS-1:0] req_tdata,
   input  logic                      req_tuser,
   input  qstat_type                 qstat,
   output logic                      push,
   output qentry_type                push_entry
);

   logic [COORD_BITS-1:0] col;
   logic [COORD_BITS-1:0] row;
   logic [TILE_BITS-1:0]  new_value;
   logic [EC_BITS-1:0]    cols_eff;
   logic [ER_BITS-1:0]    rows_eff;
   logic                  take;

   logic                  stg_valid_ff, stg_valid_in;
   logic                  stg_cmd_ff, stg_cmd_in;
   logic                  stg_inb_ff, stg_inb_in;
   logic [PROD_BITS-1:0]  stg_prod_ff, stg_prod_in;
   logic [COL_BITS-1:0]   stg_x_ff, stg_x_in;
   logic [TILE_BITS-1:0]  stg_value_ff, stg_value_in;

   assign col       = req_tdata[COORD_BITS-1:0];
   assign row       = req_tdata[2*COORD_BITS-1:COORD_BITS];
   assign new_value = req_tdata[2*COORD_BITS+TILE_BITS-1:2*COORD_BITS];
   assign cols_eff  = eff_columns(cfg.map_columns);
   assign rows_eff  = eff_rows(cfg.map_rows);

   assign push       = stg_valid_ff && !qstat.full;
   assign req_tready = !clearing && (!stg_valid_ff || !qstat.full);
   assign take       = req_tvalid && req_tready;

   always_comb begin
      stg_valid_in = take ? 1'b1 : (push ? 1'b0 : stg_valid_ff);
      stg_cmd_in   = req_tuser;
      // negative coordinates fail on the sign bit, the rest by magnitude
      stg_inb_in   = !col[COORD_BITS-1] && !row[COORD_BITS-1] &&
                     (int'(col[COORD_BITS-2:0]) < int'(cols_eff)) &&
                     (int'(row[COORD_BITS-2:0]) < int'(rows_eff));
      stg_prod_in  = PROD_BITS'(cols_eff) * PROD_BITS'(row[ROW_BITS-1:0]);
      stg_x_in     = col[COL_BITS-1:0];
      stg_value_in = new_value;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stg_valid_ff <= 1'b0;
      end else begin
         stg_valid_ff <= stg_valid_in;
      end
      if (take) begin
         stg_cmd_ff   <= stg_cmd_in;
         stg_inb_ff   <= stg_inb_in;
         stg_prod_ff  <= stg_prod_in;
         stg_x_ff     <= stg_x_in;
         stg_value_ff <= stg_value_in;
      end
   end

   always_comb begin
      push_entry.cmd   = stg_cmd_ff;
      push_entry.inb   = stg_inb_ff;
      push_entry.addr  = ADDR_BITS'(stg_prod_ff) + ADDR_BITS'(stg_x_ff);
      push_entry.value = stg_value_ff;
   end

endmodule

/* hdl/tmst_queue.sv */
// ----------------------------------------------------------------------------
// Tile map store command queue
// Short FIFO between the front end and the back end.
// ----------------------------------------------------------------------------
module tmst_queue import tmst_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  qentry_type push_entry,
   input  logic       pop,
   output qentry_type head,
   output qstat_type  qstat
);

   qentry_type           entry_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_BITS-1:0] count_ff, count_in;

   function automatic logic [QPTR_BITS-1:0] ptr_next(logic [QPTR_BITS-1:0] p);
      logic [QPTR_BITS-1:0] r;
      if (int'(p) == QUEUE_DEPTH - 1) r = '0;
      else r = p + QPTR_BITS'(1);
      return r;
   endfunction

   always_comb begin
      wr_ptr_in = push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) count_in = count_ff + QCNT_BITS'(1);
      if (pop && !push) count_in = count_ff - QCNT_BITS'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign head        = entry_ff[rd_ptr_ff];
   assign qstat.full  = int'(count_ff) == QUEUE_DEPTH;
   assign qstat.empty = count_ff == '0;

endmodule

/* hdl/tmst_back.sv */
// ----------------------------------------------------------------------------
// Tile map store back end
// Clears the store after reset, then runs each queued item: a read of the tile
// memory, and for in-bounds writes a write-back with tally updates.
// ----------------------------------------------------------------------------
module tmst_back import tmst_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  cfg_type                   cfg,
   input  qentry_type                head,
   input  qstat_type                 qstat,
   output logic                      pop,
   output bk_status_type             bk_status,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [RSP_TDATA_BITS-1:0] rsp_tdata,
   output logic                      rsp_tuser
);

   typedef enum logic {
      BK_ISSUE,
      BK_FINISH
   } bk_state_type;

   bk_state_type          state_ff, state_in;
   logic                  clearing_ff, clearing_in;
   logic [ADDR_BITS-1:0]  clr_addr_ff, clr_addr_in;
   logic [TALLY_BITS-1:0] walk_ff, walk_in;
   logic [TALLY_BITS-1:0] res_ff, res_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [TILE_BITS-1:0]  rsp_tile_ff, rsp_tile_in;
   logic                  rsp_inb_ff, rsp_inb_in;

   logic                  rd_en, wr_en;
   logic [ADDR_BITS-1:0]  wr_addr;
   logic [TILE_BITS-1:0]  wr_data, old;
   logic                  out_free, finish, do_write;
   logic                  ow, nw, orr, nr;

   function automatic logic [TALLY_BITS-1:0] tally_up(logic [TALLY_BITS-1:0] t);
      return (t == TALLY_MAX) ? t : t + TALLY_BITS'(1);
   endfunction

   function automatic logic [TALLY_BITS-1:0] tally_down(logic [TALLY_BITS-1:0] t);
      return (t == '0) ? t : t - TALLY_BITS'(1);
   endfunction

   tmst_ram #(
      .WIDTH (TILE_BITS),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (head.addr),
      .rd_data (old)
   );

   always_comb begin
      out_free = !rsp_valid_ff || rsp_tready;
      finish   = (state_ff == BK_FINISH) && out_free;
      rd_en    = (state_ff == BK_ISSUE) && !clearing_ff && !qstat.empty;
      do_write = finish && head.inb && (head.cmd == CMD_WRITE);
      wr_en    = clearing_ff || do_write;
      wr_addr  = clearing_ff ? clr_addr_ff : head.addr;
      wr_data  = clearing_ff ? '0 : head.value;
      pop      = finish;

      ow  = old == cfg.walkable_code;
      nw  = head.value == cfg.walkable_code;
      orr = old == cfg.resource_code;
      nr  = head.value == cfg.resource_code;

      clearing_in = clearing_ff && (clr_addr_ff != ADDR_BITS'(STORE_DEPTH - 1));
      clr_addr_in = clr_addr_ff + ADDR_BITS'(1);

      state_in = state_ff;
      unique case (state_ff)
         BK_ISSUE:  if (rd_en) state_in = BK_FINISH;
         BK_FINISH: if (finish) state_in = BK_ISSUE;
      endcase

      walk_in = walk_ff;
      res_in  = res_ff;
      if (do_write) begin
         if (nw && !ow) walk_in = tally_up(walk_ff);
         if (!nw && ow) walk_in = tally_down(walk_ff);
         if (nr && !orr) res_in = tally_up(res_ff);
         if (!nr && orr) res_in = tally_down(res_ff);
      end

      // out-of-bounds reads give the walkable code, writes give zero
      if (head.cmd == CMD_WRITE) rsp_tile_in = '0;
      else if (head.inb) rsp_tile_in = old;
      else rsp_tile_in = cfg.walkable_code;
      rsp_inb_in = head.inb;

      rsp_valid_in = finish ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_ISSUE;
         clearing_ff  <= 1'b1;
         clr_addr_ff  <= '0;
         walk_ff      <= '0;
         res_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         rsp_tile_ff  <= '0;
         rsp_inb_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clearing_ff  <= clearing_in;
         clr_addr_ff  <= clr_addr_in;
         walk_ff      <= walk_in;
         res_ff       <= res_in;
         rsp_valid_ff <= rsp_valid_in;
         if (finish) begin
            rsp_tile_ff <= rsp_tile_in;
            rsp_inb_ff  <= rsp_inb_in;
         end
      end
   end

   assign bk_status.clearing = clearing_ff;
   assign bk_status.finish   = finish;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {RSP_PAD_BITS'(0), res_ff, walk_ff, rsp_tile_ff};
   assign rsp_tuser  = rsp_inb_ff;

endmodule

/* hdl/tile_map_store_with_tallies.sv */
// ----------------------------------------------------------------------------
// Tile map store with tallies
// Byte tile map with signed coordinates and walkable/resource tallies.
// req_* takes one read or write item; rsp_* returns one result per item with
// the tile byte, the in-bounds flag and both tallies. csr_* writes the map
// size and tile codes and should only be used while no item is in flight.
// From req accept an item passes the front stage register, the queue, the back
// end's issue state, which reads the tile memory, and its finish state, which
// compares, writes back and updates the tallies, then the response register.
// The back end reads no new item until the last one has finished, as the store's
// read is registered. After reset the store is cleared one tile per cycle, all
// STORE_DEPTH (65536) tiles; req_tready stays low meanwhile, while csr writes
// are taken. Tallies and registers reset at once. When rsp_tready is low the
// result holds; a two-entry queue and the front stage keep taking up to three
// more items before req_tready drops.
// ----------------------------------------------------------------------------
`include "tile_map_store_with_tallies_macros.svh"

module tile_map_store_with_tallies import tmst_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   // configuration write port
   input  logic                      csr_wr_en,
   input  logic [CSR_IDX_BITS-1:0]   csr_index,
   input  logic [CSR_BITS-1:0]       csr_wdata,
   // request channel
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [REQ_TDATA_BITS-1:0] req_tdata,  // col[15:0], row[31:16], new_value[39:32]
   input  logic                      req_tuser,  // cmd
   // response channel
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [RSP_TDATA_BITS-1:0] rsp_tdata,  // tile_value[7:0], walkable_tally[24:8],
                                                 // resource_tally[41:25], zeros above
   output logic                      rsp_tuser   // in_bounds
);

   cfg_type       cfg_ff, cfg_in;
   qstat_type     qstat;
   qentry_type    push_entry, head;
   logic          push, pop;
   bk_status_type bk_status;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_MAP_COLUMNS:   cfg_in.map_columns   = csr_wdata[DIM_BITS-1:0];
            CSR_MAP_ROWS:      cfg_in.map_rows      = csr_wdata[DIM_BITS-1:0];
            CSR_WALKABLE_CODE: cfg_in.walkable_code = csr_wdata[CODE_BITS-1:0];
            CSR_RESOURCE_CODE: cfg_in.resource_code = csr_wdata[CODE_BITS-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.map_columns   <= RST_MAP_COLUMNS;
         cfg_ff.map_rows      <= RST_MAP_ROWS;
         cfg_ff.walkable_code <= RST_WALKABLE_CODE;
         cfg_ff.resource_code <= RST_RESOURCE_CODE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   tmst_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .clearing   (bk_status.clearing),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .qstat      (qstat),
      .push       (push),
      .push_entry (push_entry)
   );

   tmst_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .qstat      (qstat)
   );

   tmst_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .head       (head),
      .qstat      (qstat),
      .pop        (pop),
      .bk_status  (bk_status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // no item enters while the store is being cleared
   `TMST_ASSERT_IMPL(a_no_take_clearing, clock, reset, bk_status.clearing, !req_tready)
   // an item only completes from a non-empty queue
   `TMST_ASSERT_IMPL(a_finish_has_item, clock, reset, bk_status.finish, !qstat.empty)
   // result word and tallies move only when an item completes
   `TMST_ASSERT_NEXT(a_rsp_hold, clock, reset, !bk_status.finish, $stable(rsp_tdata))

endmodule
